>>> hdl/kpss_pkg.sv
package kpss_pkg;

  // Encoder counts over one turn; the count wraps over 0..COUNTS_PER_TURN.
  localparam int COUNTS_PER_TURN = 160;
  localparam int PWM_TOP         = 1023;
  localparam int MAX_ANGLE       = 360;
  localparam int REF_RESET       = 90;

  localparam int GAIN_RESET      = 256;
  localparam int PWM_BASE_RESET  = 25;
  localparam int DEAD_BAND_RESET = 0;

  // Field widths.
  localparam int MODE_W   = 2;
  localparam int DIGIT_W  = 4;
  localparam int POS_W    = 8;
  localparam int GAIN_W   = 16;
  localparam int DUTY_W   = 10;
  localparam int DB_W     = 8;
  localparam int STAT_W   = 2;
  localparam int ANGLE_W  = 11;
  localparam int MAG_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W    = 16;

  // Shared multiplier operand widths and product width.
  localparam int MUL_A_W = 18;
  localparam int MUL_B_W = 26;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Constant division by multiplication with a rounded-up reciprocal.
  localparam int RECIP_SH   = 26;
  localparam int REF_RECIP  = ((1 << RECIP_SH) + MAX_ANGLE - 1) / MAX_ANGLE;
  localparam int DUTY_RECIP = ((1 << RECIP_SH) + COUNTS_PER_TURN - 1) / COUNTS_PER_TURN;

  // Q8.8 clamp limit on the drive magnitude.
  localparam int MAG_LIMIT = COUNTS_PER_TURN * 256;

  typedef enum logic [MODE_W-1:0] {
    MODE_ENCODER = 2'd0,
    MODE_DIGIT   = 2'd1,
    MODE_COMMIT  = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ENTRY_NONE     = 2'd0,
    ENTRY_ACCEPTED = 2'd1,
    ENTRY_REJECTED = 2'd2
  } entry_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN      = 2'd0,
    CFG_PWM_BASE  = 2'd1,
    CFG_DEAD_BAND = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    MUL_ANGLE = 3'd0,
    MUL_RECIP = 3'd1,
    MUL_GAIN  = 3'd2,
    MUL_SPAN  = 3'd3,
    MUL_DUTY  = 3'd4
  } mul_sel_t;

  typedef struct packed {
    logic     ld_item;
    logic     upd;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     ld_ref;
    logic     ld_err;
    logic     ld_clamp;
    logic     ld_out;
  } kpss_cmd_t;

  typedef struct packed {
    logic take_angle;
    logic out_free;
  } kpss_sts_t;

endpackage

>>> hdl/kpss_ctrl.sv
module kpss_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  kpss_pkg::kpss_sts_t sts,
  output kpss_pkg::kpss_cmd_t cmd
);
  import kpss_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_UPD  = 10'b00_0000_0010,
    S_MA   = 10'b00_0000_0100,
    S_MR   = 10'b00_0000_1000,
    S_REF  = 10'b00_0001_0000,
    S_ERR  = 10'b00_0010_0000,
    S_CLMP = 10'b00_0100_0000,
    S_DMUL = 10'b00_1000_0000,
    S_DDIV = 10'b01_0000_0000,
    S_OUT  = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.mul_sel  = MUL_GAIN;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.ld_item = 1'b1;
          state_nxt   = S_UPD;
        end
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = sts.take_angle ? S_MA : S_ERR;
      end
      S_MA: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_ANGLE;
        state_nxt   = S_MR;
      end
      S_MR: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_RECIP;
        state_nxt   = S_REF;
      end
      S_REF: begin
        cmd.ld_ref = 1'b1;
        state_nxt  = S_ERR;
      end
      S_ERR: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_GAIN;
        cmd.ld_err  = 1'b1;
        state_nxt   = S_CLMP;
      end
      S_CLMP: begin
        cmd.ld_clamp = 1'b1;
        state_nxt    = S_DMUL;
      end
      S_DMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SPAN;
        state_nxt   = S_DDIV;
      end
      S_DDIV: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DUTY;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.ld_out = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hdl/kpss_dp.sv
module kpss_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [kpss_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [kpss_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic [kpss_pkg::MODE_W-1:0]   in_mode,
  input  logic                          in_direction,
  input  logic [kpss_pkg::DIGIT_W-1:0]  in_key_digit,
  input  kpss_pkg::kpss_cmd_t           cmd,
  output kpss_pkg::kpss_sts_t           sts,
  input  logic                          out_tready,
  output logic                          out_tvalid,
  output logic [kpss_pkg::DUTY_W-1:0]   out_duty_forward,
  output logic [kpss_pkg::DUTY_W-1:0]   out_duty_reverse,
  output logic [kpss_pkg::POS_W-1:0]    out_shaft_position,
  output logic [kpss_pkg::POS_W-1:0]    out_target_position,
  output logic [kpss_pkg::STAT_W-1:0]   out_entry_status
);
  import kpss_pkg::*;

  // Configuration registers.
  logic [GAIN_W-1:0] gain_r;
  logic [DUTY_W-1:0] pwm_base_r;
  logic [DB_W-1:0]   dead_band_r;

  // Captured item.
  logic [MODE_W-1:0]  mode_r;
  logic               dir_r;
  logic [DIGIT_W-1:0] key_r;

  // Servo state.
  logic [POS_W-1:0]   position_r;
  logic [POS_W-1:0]   reference_r;
  logic [1:0]         dcnt_r;
  logic [DIGIT_W-1:0] hund_r, tens_r, ones_r;
  logic [STAT_W-1:0]  status_r;
  logic [ANGLE_W-1:0] angle_r;

  // Arithmetic pipeline registers.
  logic [PROD_W-1:0]  prod_r;
  logic               neg_r, enz_r;
  logic [MAG_W-1:0]   mag_r;
  logic               drive_r;

  // Output register.
  logic               out_valid_r;
  logic [DUTY_W-1:0]  fwd_r, rev_r;
  logic [POS_W-1:0]   shaft_r, target_r;
  logic [STAT_W-1:0]  ostat_r;

  logic [ANGLE_W-1:0] angle_c;
  logic               commit_full;
  logic               neg_c;
  logic [POS_W-1:0]   emag_c;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod_c;
  logic [DUTY_W-1:0]  span_c;
  logic [DUTY_W:0]    duty_sum;
  logic [DUTY_W-1:0]  duty_c;
  logic [MAG_W-1:0]   mag_c;

  // Held digits to an angle; shifts and adds only.
  assign angle_c = ANGLE_W'(hund_r) * ANGLE_W'(100) + ANGLE_W'(tens_r) * ANGLE_W'(10)
                 + ANGLE_W'(ones_r);
  assign commit_full     = (mode_r == MODE_COMMIT) && (dcnt_r == 2'd3);
  assign sts.take_angle  = commit_full && (angle_c <= ANGLE_W'(MAX_ANGLE));
  assign sts.out_free    = !out_valid_r || out_tready;

  assign neg_c  = reference_r < position_r;
  assign emag_c = neg_c ? (position_r - reference_r) : (reference_r - position_r);

  assign span_c = (pwm_base_r >= DUTY_W'(PWM_TOP)) ? '0 : (DUTY_W'(PWM_TOP) - pwm_base_r);

  // The dead band is tested against the clamped magnitude.
  assign mag_c = (prod_r > PROD_W'(MAG_LIMIT)) ? MAG_W'(MAG_LIMIT) : prod_r[MAG_W-1:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      MUL_ANGLE: begin
        mul_a = MUL_A_W'(angle_r);
        mul_b = MUL_B_W'(COUNTS_PER_TURN);
      end
      MUL_RECIP: begin
        mul_a = MUL_A_W'(prod_r[16:0]);
        mul_b = MUL_B_W'(REF_RECIP);
      end
      MUL_GAIN: begin
        mul_a = MUL_A_W'(emag_c);
        mul_b = MUL_B_W'(gain_r);
      end
      MUL_SPAN: begin
        mul_a = MUL_A_W'(mag_r);
        mul_b = MUL_B_W'(span_c);
      end
      MUL_DUTY: begin
        mul_a = prod_r[8 +: MUL_A_W];
        mul_b = MUL_B_W'(DUTY_RECIP);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_c = PROD_W'(mul_a) * PROD_W'(mul_b);

  // The quotient of the duty scaling never exceeds the span, so it fits the duty width.
  assign duty_sum = {1'b0, pwm_base_r} + {1'b0, prod_r[RECIP_SH +: DUTY_W]};
  assign duty_c   = duty_sum[DUTY_W] ? DUTY_W'(PWM_TOP) : duty_sum[DUTY_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r      <= GAIN_W'(GAIN_RESET);
      pwm_base_r  <= DUTY_W'(PWM_BASE_RESET);
      dead_band_r <= DB_W'(DEAD_BAND_RESET);
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_GAIN:      gain_r      <= cfg_wdata[GAIN_W-1:0];
        CFG_PWM_BASE:  pwm_base_r  <= cfg_wdata[DUTY_W-1:0];
        CFG_DEAD_BAND: dead_band_r <= cfg_wdata[DB_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      mode_r <= in_mode;
      dir_r  <= in_direction;
      key_r  <= in_key_digit;
    end
    if (cmd.mul_en) begin
      prod_r <= prod_c;
    end
    if (cmd.upd) begin
      angle_r <= angle_c;
    end
    if (cmd.ld_err) begin
      neg_r <= neg_c;
      enz_r <= (emag_c != '0);
    end
    if (cmd.ld_clamp) begin
      mag_r   <= mag_c;
      drive_r <= enz_r && (mag_c > {dead_band_r, 8'd0});
    end
    if (cmd.ld_out) begin
      fwd_r    <= (drive_r && !neg_r) ? duty_c : '0;
      rev_r    <= (drive_r &&  neg_r) ? duty_c : '0;
      shaft_r  <= position_r;
      target_r <= reference_r;
      ostat_r  <= status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r  <= '0;
      reference_r <= POS_W'(REF_RESET);
      dcnt_r      <= '0;
      hund_r      <= '0;
      tens_r      <= '0;
      ones_r      <= '0;
      status_r    <= ENTRY_NONE;
    end else begin
      if (cmd.upd) begin
        status_r <= ENTRY_NONE;
        case (mode_t'(mode_r))
          MODE_ENCODER: begin
            if (dir_r) begin
              position_r <= (position_r >= POS_W'(COUNTS_PER_TURN)) ? '0
                          : position_r + POS_W'(1);
            end else begin
              position_r <= (position_r == '0) ? POS_W'(COUNTS_PER_TURN)
                          : position_r - POS_W'(1);
            end
          end
          MODE_DIGIT: begin
            case (dcnt_r)
              2'd0:    hund_r <= key_r;
              2'd1:    tens_r <= key_r;
              2'd2:    ones_r <= key_r;
              default: ;
            endcase
            if (dcnt_r != 2'd3) begin
              dcnt_r <= dcnt_r + 2'd1;
            end
          end
          MODE_COMMIT: begin
            if (commit_full) begin
              dcnt_r   <= '0;
              status_r <= sts.take_angle ? ENTRY_ACCEPTED : ENTRY_REJECTED;
            end
          end
          default: ;
        endcase
      end
      if (cmd.ld_ref) begin
        reference_r <= prod_r[RECIP_SH +: POS_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.ld_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid          = out_valid_r;
  assign out_duty_forward    = fwd_r;
  assign out_duty_reverse    = rev_r;
  assign out_shaft_position  = shaft_r;
  assign out_target_position = target_r;
  assign out_entry_status    = ostat_r;

endmodule

>>> hdl/keypad_set_position_servo.sv
// An item steps through update, error, clamp, duty span and duty division, then its result
// is loaded once the output register is free; a commit key whose three digits form an
// accepted angle first rescales the reference. One item is taken at a time: the sequencer
// steps one shared multiplier through angle, gain, duty span and division products.
// Reset (rst_n low at a clock edge): position 0, reference 90, no digits held,
// gain 1.0, PWM base 25, dead band 0, no result pending.
module keypad_set_position_servo (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port.
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] direction, [4:1] key_digit, [7:5] zero
  input  logic [1:0]  in_tuser,   // [1:0] mode
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [9:0] duty_forward, [19:10] duty_reverse,
                                  // [27:20] shaft_position, [35:28] target_position,
                                  // [37:36] entry_status, [39:38] zero
);
  import kpss_pkg::*;

  kpss_cmd_t cmd;
  kpss_sts_t sts;

  logic [DUTY_W-1:0] duty_forward, duty_reverse;
  logic [POS_W-1:0]  shaft_position, target_position;
  logic [STAT_W-1:0] entry_status;

  // The controller sequences one item at a time; it takes a new transfer only when idle,
  // which it reaches as soon as the previous result sits in the output register.
  kpss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the servo state, the settings, the shared multiplier and the
  // output register that decouples the result side from the input side.
  kpss_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_addr            (cfg_addr),
    .cfg_wdata           (cfg_wdata),
    .in_mode             (in_tuser),
    .in_direction        (in_tdata[0]),
    .in_key_digit        (in_tdata[4:1]),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_tready          (out_tready),
    .out_tvalid          (out_tvalid),
    .out_duty_forward    (duty_forward),
    .out_duty_reverse    (duty_reverse),
    .out_shaft_position  (shaft_position),
    .out_target_position (target_position),
    .out_entry_status    (entry_status)
  );

  assign out_tdata = {2'b00, entry_status, target_position, shaft_position,
                      duty_reverse, duty_forward};

endmodule
